// ===== design/itoa_pkg.sv =====
// Shared types, character codes and helpers for the integer-to-ASCII formatter.
`default_nettype none

package itoa_pkg;

  localparam int VALUE_PORT_W = 32;
  localparam int FUNC_W       = 2;
  localparam int CHAR_W       = 7;

  typedef enum logic [FUNC_W-1:0] {
    FMT_DEC = 2'd0,
    FMT_BIN = 2'd1,
    FMT_OCT = 2'd2,
    FMT_HEX = 2'd3
  } fmt_t;

  typedef struct packed {
    fmt_t fmt;
    logic pad;
  } itoa_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PRE0,
    ST_PRE1,
    ST_DIG
  } itoa_st_t;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_B    = 7'h62;
  localparam logic [CHAR_W-1:0] CHAR_O    = 7'h6f;

  localparam int          HEX_PAD_LIMIT = 16;
  localparam logic [3:0]  DIGIT_TEN     = 4'd10;
  localparam logic [3:0]  BCD_ADJ_MIN   = 4'd5;
  localparam logic [3:0]  BCD_ADJ       = 4'd3;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {3'b000, d};
    if (d < DIGIT_TEN) begin
      digit_char = CHAR_ZERO + d_ext;
    end else begin
      digit_char = CHAR_A + d_ext - {3'b000, DIGIT_TEN};
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/itoa_if.sv =====
// Valid/ready channel interfaces for the formatter's request and character streams.
`default_nettype none

interface itoa_in_if;
  logic                              valid;
  logic                              ready;
  logic [itoa_pkg::VALUE_PORT_W-1:0] value;
  logic [itoa_pkg::FUNC_W-1:0]       func;

  modport source (output valid, value, func, input ready);
  modport sink   (input valid, value, func, output ready);
endinterface

interface itoa_out_if;
  logic                        valid;
  logic                        ready;
  logic [itoa_pkg::CHAR_W-1:0] char_code;
  logic                        last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

`default_nettype wire

// ===== design/itoa_front.sv =====
// Front end: accepts requests, sizes the value and classifies the format.
`default_nettype none

module itoa_front #(
  parameter int VALUE_WIDTH = 32
) (
  itoa_in_if.sink                 in_ch,
  input  logic                    q_ready,
  output logic                    push,
  output logic [VALUE_WIDTH-1:0]  push_value,
  output itoa_pkg::itoa_ctl_t     push_ctl
);

  localparam int COPY_W = (VALUE_WIDTH < itoa_pkg::VALUE_PORT_W) ?
                          VALUE_WIDTH : itoa_pkg::VALUE_PORT_W;

  logic [VALUE_WIDTH-1:0] val_ext;
  itoa_pkg::fmt_t         fmt;

  always_comb begin
    val_ext = VALUE_WIDTH'(in_ch.value[COPY_W-1:0]);
    fmt     = itoa_pkg::fmt_t'(in_ch.func);
    push_value   = val_ext;
    push_ctl.fmt = fmt;
    // hex below sixteen gets a leading zero
    push_ctl.pad = (fmt == itoa_pkg::FMT_HEX) &&
                   (val_ext < VALUE_WIDTH'(itoa_pkg::HEX_PAD_LIMIT));
    in_ch.ready  = q_ready;
    push         = in_ch.valid && q_ready;
  end

endmodule

`default_nettype wire

// ===== design/itoa_queue.sv =====
// Two-entry request queue between the front end and the digit engine.
`default_nettype none

module itoa_queue #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [VALUE_WIDTH-1:0]  push_value,
  input  itoa_pkg::itoa_ctl_t     push_ctl,
  output logic                    push_ready,
  input  logic                    pop,
  output logic                    pop_valid,
  output logic [VALUE_WIDTH-1:0]  pop_value,
  output itoa_pkg::itoa_ctl_t     pop_ctl
);

  logic [VALUE_WIDTH-1:0] value_r [2];
  itoa_pkg::itoa_ctl_t    ctl_r   [2];
  logic                   wr_ptr_r, wr_ptr_nxt;
  logic                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             count_r,  count_nxt;

  always_comb begin
    push_ready = (count_r != 2'd2);
    pop_valid  = (count_r != 2'd0);
    pop_value  = value_r[rd_ptr_r];
    pop_ctl    = ctl_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      value_r[wr_ptr_r] <= push_value;
      ctl_r[wr_ptr_r]   <= push_ctl;
    end
  end

endmodule

`default_nettype wire

// ===== design/itoa_back.sv =====
// Digit engine: decimal conversion, leading-zero skip, prefix and digit emission.
`default_nettype none

module itoa_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pop_valid,
  input  logic [VALUE_WIDTH-1:0]  pop_value,
  input  itoa_pkg::itoa_ctl_t     pop_ctl,
  output logic                    pop,
  itoa_out_if.source              out_ch
);

  localparam int NDEC   = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NOCT   = (VALUE_WIDTH + 2) / 3;
  localparam int NHEX   = (VALUE_WIDTH + 3) / 4;
  localparam int DW     = 4 * NDEC;
  localparam int SH_BIN = DW - VALUE_WIDTH;
  localparam int SH_OCT = DW - 3 * NOCT;
  localparam int SH_HEX = DW - 4 * NHEX;
  localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

  itoa_pkg::itoa_st_t         st_r,  st_nxt;
  logic [DW-1:0]              dig_r, dig_nxt;
  logic [VALUE_WIDTH-1:0]     bin_r, bin_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  itoa_pkg::fmt_t             fmt_r, fmt_nxt;
  logic                       pad_r, pad_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [itoa_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       can_emit;
  logic [3:0]                 top_digit;
  logic [DW-1:0]              dig_shift;
  logic [DW-1:0]              bcd_adj;
  logic                       has_prefix;

  always_comb begin
    can_emit = !out_valid_r || out_ch.ready;

    case (fmt_r)
      itoa_pkg::FMT_BIN: begin
        top_digit = {3'b000, dig_r[DW-1]};
        dig_shift = dig_r << 1;
      end
      itoa_pkg::FMT_OCT: begin
        top_digit = {1'b0, dig_r[DW-1 -: 3]};
        dig_shift = dig_r << 3;
      end
      default: begin
        top_digit = dig_r[DW-1 -: 4];
        dig_shift = dig_r << 4;
      end
    endcase

    // add three to every BCD digit of five or more before the shift
    for (int j = 0; j < NDEC; j++) begin
      bcd_adj[4*j +: 4] = (dig_r[4*j +: 4] >= itoa_pkg::BCD_ADJ_MIN) ?
                          dig_r[4*j +: 4] + itoa_pkg::BCD_ADJ : dig_r[4*j +: 4];
    end

    has_prefix = (fmt_r == itoa_pkg::FMT_BIN) || (fmt_r == itoa_pkg::FMT_OCT);

    st_nxt        = st_r;
    dig_nxt       = dig_r;
    bin_nxt       = bin_r;
    cnt_nxt       = cnt_r;
    fmt_nxt       = fmt_r;
    pad_nxt       = pad_r;
    pop           = 1'b0;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (st_r)
      itoa_pkg::ST_IDLE: begin
        if (pop_valid) begin
          pop     = 1'b1;
          fmt_nxt = pop_ctl.fmt;
          pad_nxt = pop_ctl.pad;
          case (pop_ctl.fmt)
            itoa_pkg::FMT_DEC: begin
              bin_nxt = pop_value;
              dig_nxt = '0;
              cnt_nxt = CNT_W'(VALUE_WIDTH);
              st_nxt  = itoa_pkg::ST_CONV;
            end
            itoa_pkg::FMT_BIN: begin
              dig_nxt = DW'(pop_value) << SH_BIN;
              cnt_nxt = CNT_W'(VALUE_WIDTH);
              st_nxt  = itoa_pkg::ST_SKIP;
            end
            itoa_pkg::FMT_OCT: begin
              dig_nxt = DW'(pop_value) << SH_OCT;
              cnt_nxt = CNT_W'(NOCT);
              st_nxt  = itoa_pkg::ST_SKIP;
            end
            default: begin
              dig_nxt = DW'(pop_value) << SH_HEX;
              cnt_nxt = CNT_W'(NHEX);
              st_nxt  = itoa_pkg::ST_SKIP;
            end
          endcase
        end
      end

      itoa_pkg::ST_CONV: begin
        dig_nxt = {bcd_adj[DW-2:0], bin_r[VALUE_WIDTH-1]};
        bin_nxt = bin_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt = CNT_W'(NDEC);
          st_nxt  = itoa_pkg::ST_SKIP;
        end
      end

      itoa_pkg::ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if ((cnt_r > CNT_W'(1)) && (top_digit == 4'd0)) begin
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (has_prefix || pad_r) begin
          st_nxt = itoa_pkg::ST_PRE0;
        end else begin
          st_nxt = itoa_pkg::ST_DIG;
        end
      end

      itoa_pkg::ST_PRE0: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::CHAR_ZERO;
          out_last_nxt  = 1'b0;
          st_nxt        = has_prefix ? itoa_pkg::ST_PRE1 : itoa_pkg::ST_DIG;
        end
      end

      itoa_pkg::ST_PRE1: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = (fmt_r == itoa_pkg::FMT_BIN) ?
                          itoa_pkg::CHAR_B : itoa_pkg::CHAR_O;
          out_last_nxt  = 1'b0;
          st_nxt        = itoa_pkg::ST_DIG;
        end
      end

      itoa_pkg::ST_DIG: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::digit_char(top_digit);
          out_last_nxt  = (cnt_r == CNT_W'(1));
          dig_nxt       = dig_shift;
          cnt_nxt       = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            st_nxt = itoa_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        st_nxt = itoa_pkg::ST_IDLE;
      end
    endcase

    out_ch.valid     = out_valid_r;
    out_ch.char_code = out_char_r;
    out_ch.last      = out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= itoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    bin_r      <= bin_nxt;
    cnt_r      <= cnt_nxt;
    fmt_r      <= fmt_nxt;
    pad_r      <= pad_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ===== design/int_to_ascii_radix_formatter_top.sv =====
// Integer-to-ASCII radix formatter: turns a value into its character string.
//
// in_ch carries one request: value (read unsigned, low VALUE_WIDTH bits) and
// func (0 decimal, 1 binary "0b", 2 octal "0o", 3 lowercase hex padded to two
// digits). out_ch returns one ASCII character per transfer, most significant
// first, with last set on the final character of each string.
// A two-entry queue sits between the request side and the digit engine, so up
// to two requests are taken while a string is still going out.
// Per request the engine loads the value, then for decimal runs a
// shift-and-add-3 BCD conversion over all VALUE_WIDTH bits, then drops
// leading zero digits one at a time, leaves the skip, and emits the
// characters one by one. Binary, octal and hex skip the conversion.
// Reset (rst_n low, synchronous) empties the queue, the engine and the output
// register. When the receiver holds ready low the output register holds its
// character, the engine halts before its next one; requests queue until full.
`default_nettype none

module int_to_ascii_radix_formatter_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  itoa_in_if.sink      in_ch,
  itoa_out_if.source   out_ch
);

  logic                   q_ready;
  logic                   push;
  logic [VALUE_WIDTH-1:0] push_value;
  itoa_pkg::itoa_ctl_t    push_ctl;
  logic                   pop;
  logic                   pop_valid;
  logic [VALUE_WIDTH-1:0] pop_value;
  itoa_pkg::itoa_ctl_t    pop_ctl;

  itoa_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .in_ch      (in_ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_value (push_value),
    .push_ctl   (push_ctl)
  );

  itoa_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_value (push_value),
    .push_ctl   (push_ctl),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_value  (pop_value),
    .pop_ctl    (pop_ctl)
  );

  itoa_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_value  (pop_value),
    .pop_ctl    (pop_ctl),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== bench/char_stream_checker.sv =====
// Checker for the formatter: predicts each request's character string and compares the output stream.
`timescale 1ns / 1ps

module char_stream_checker (
  input  logic clk,
  input  logic rst_n,
  itoa_in_if   in_ch,
  itoa_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] char_code;
    logic                        last;
  } char_item_t;

  char_item_t expected_chars[$];
  int         errors;

  initial begin
    errors     = 0;
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [itoa_pkg::CHAR_W-1:0] ascii_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(d);
    end else begin
      return itoa_pkg::CHAR_A + itoa_pkg::CHAR_W'(d) - itoa_pkg::CHAR_W'(10);
    end
  endfunction

  // Render one request into the characters it must produce, most significant first.
  task automatic expect_string(input logic [itoa_pkg::VALUE_PORT_W-1:0] value,
                               input itoa_pkg::fmt_t fmt);
    logic [3:0]                        digits[itoa_pkg::VALUE_PORT_W+1];
    logic [itoa_pkg::VALUE_PORT_W-1:0] rest;
    logic [itoa_pkg::VALUE_PORT_W-1:0] base;
    int                                count;
    rest  = value;
    count = 0;
    case (fmt)
      itoa_pkg::FMT_BIN: base = 2;
      itoa_pkg::FMT_OCT: base = 8;
      itoa_pkg::FMT_HEX: base = 16;
      default: base = 10;
    endcase
    do begin
      digits[count] = 4'(rest % base);
      rest = rest / base;
      count++;
    end while (rest != 0);
    case (fmt)
      itoa_pkg::FMT_BIN: begin
        expected_chars.push_back('{itoa_pkg::CHAR_ZERO, 1'b0});
        expected_chars.push_back('{itoa_pkg::CHAR_B, 1'b0});
      end
      itoa_pkg::FMT_OCT: begin
        expected_chars.push_back('{itoa_pkg::CHAR_ZERO, 1'b0});
        expected_chars.push_back('{itoa_pkg::CHAR_O, 1'b0});
      end
      itoa_pkg::FMT_HEX: begin
        if (value < itoa_pkg::HEX_PAD_LIMIT) begin
          expected_chars.push_back('{itoa_pkg::CHAR_ZERO, 1'b0});
        end
      end
      default: ;
    endcase
    for (int i = count - 1; i >= 0; i--) begin
      expected_chars.push_back('{ascii_digit(digits[i]), i == 0});
    end
  endtask

  always @(posedge clk) begin
    char_item_t want;
    if (!rst_n) begin
      expected_chars.delete();
    end else begin
      // Pop before push: a character can never leave in the cycle its request enters.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character 0x%02h (last=%0b) with no request pending",
                 out_ch.char_code, out_ch.last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.char_code !== want.char_code) begin
            $error("char_code: expected 0x%02h, got 0x%02h", want.char_code, out_ch.char_code);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expect_string(in_ch.value, itoa_pkg::fmt_t'(in_ch.func));
      end
    end
    fail_count <= errors;
    pending    <= expected_chars.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the formatter testbench: clock, reset, request stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_REQUESTS = 500;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 80;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  bit   calm;

  itoa_in_if  in_ch();
  itoa_out_if out_ch();

  int_to_ascii_radix_formatter_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_stream_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; none at all during calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [itoa_pkg::VALUE_PORT_W-1:0] pick_value();
    logic [itoa_pkg::VALUE_PORT_W-1:0] v;
    int                                k;
    case ($urandom_range(0, 9))
      4: v = $urandom_range(0, 40);
      5: begin
        v = 1 << $urandom_range(0, itoa_pkg::VALUE_PORT_W - 1);
        v = v + $urandom_range(0, 2) - 1;
      end
      6: v = $urandom & ((1 << $urandom_range(1, itoa_pkg::VALUE_PORT_W - 1)) - 1);
      7: begin
        // Hold near decimal digit-count boundaries.
        v = 1;
        k = $urandom_range(0, 9);
        repeat (k) v = v * 10;
        v = v - $urandom_range(0, 1);
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_request(input logic [itoa_pkg::VALUE_PORT_W-1:0] value,
                              input itoa_pkg::fmt_t fmt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.func  <= fmt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every predicted character has come out.
  task automatic drain_outstanding();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_all_formats(input logic [itoa_pkg::VALUE_PORT_W-1:0] value);
    send_request(value, itoa_pkg::FMT_DEC);
    send_request(value, itoa_pkg::FMT_BIN);
    send_request(value, itoa_pkg::FMT_OCT);
    send_request(value, itoa_pkg::FMT_HEX);
  endtask

  // Receiver: stall for a random gap, then take one character.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("int_to_ascii_radix_formatter_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    itoa_pkg::fmt_t fmt;
    calm        = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.func  <= itoa_pkg::FMT_DEC;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero and all-ones in every format, then the boundaries of each radix.
    send_all_formats('0);
    send_all_formats('1);
    send_request(32'd1, itoa_pkg::FMT_HEX);
    send_request(32'd15, itoa_pkg::FMT_HEX);
    send_request(32'd16, itoa_pkg::FMT_HEX);
    send_request(32'hdeadbeef, itoa_pkg::FMT_HEX);
    send_request(32'd9, itoa_pkg::FMT_DEC);
    send_request(32'd10, itoa_pkg::FMT_DEC);
    send_request(32'd999999999, itoa_pkg::FMT_DEC);
    send_request(32'd1000000000, itoa_pkg::FMT_DEC);
    send_request(32'd1, itoa_pkg::FMT_BIN);
    send_request(32'h80000000, itoa_pkg::FMT_BIN);
    send_request(32'd7, itoa_pkg::FMT_OCT);
    send_request(32'd8, itoa_pkg::FMT_OCT);
    send_request(32'h55555555, itoa_pkg::FMT_BIN);
    send_request(32'haaaaaaaa, itoa_pkg::FMT_OCT);
    drain_outstanding();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if ($urandom_range(0, 39) == 0) calm = !calm;
      if (n == RANDOM_REQUESTS / 2) drain_outstanding();
      fmt = itoa_pkg::fmt_t'($urandom_range(int'(itoa_pkg::FMT_DEC),
                                            int'(itoa_pkg::FMT_HEX)));
      send_request(pick_value(), fmt);
    end

    drain_outstanding();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("int_to_ascii_radix_formatter_top: match");
    end else begin
      $display("int_to_ascii_radix_formatter_top: mismatch");
    end
    $finish;
  end

endmodule
